>>> rtl/hdlctx_pkg.sv
package hdlctx_pkg;

   // Operation codes of an input item
   typedef enum logic [1:0] {
      OP_STUFFED = 2'd0,
      OP_PLAIN   = 2'd1,
      OP_FCS     = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   localparam logic [15:0] CRC_POLY = 16'h8408;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [2:0]  ONES_MAX = 3'd7;
   localparam logic [2:0]  ONES_STUFF = 3'd5;
   localparam logic [4:0]  BYTE_BITS = 5'd8;
   localparam logic [4:0]  FCS_BITS = 5'd16;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] data_byte;
      logic       restart_crc;
   } req_type;

   typedef struct packed {
      logic tone;
      logic stuffed;
      logic last;
   } rsp_type;

   // Commands from the sequencer to the bit unit
   typedef struct packed {
      logic restart;
      logic bit_step;
      logic stuff_step;
      logic bit_val;
      logic stuffing;
   } cmd_type;

   // Status from the bit unit back to the sequencer
   typedef struct packed {
      logic [15:0] crc;
      logic        sym_tone;
      logic        need_stuff;
   } unit_type;

endpackage

>>> rtl/hdlctx_bit_unit.sv
module hdlctx_bit_unit (
   input  logic                clock,
   input  logic                reset,
   input  hdlctx_pkg::cmd_type cmd,
   output hdlctx_pkg::unit_type unit
);
   import hdlctx_pkg::*;

   logic [15:0] crc_ff, crc_in;
   logic        tone_ff, tone_in;
   logic [2:0]  ones_ff, ones_in;
   logic [2:0]  ones_inc;
   logic [15:0] crc_step;
   logic        sym_tone;

   // Saturating run count, CRC shift and line symbol for the current bit
   always_comb begin
      ones_inc = (ones_ff == ONES_MAX) ? ONES_MAX : ones_ff + 3'd1;
      crc_step = {1'b0, crc_ff[15:1]};
      if (crc_ff[0] != cmd.bit_val) begin
         crc_step = crc_step ^ CRC_POLY;
      end
      sym_tone = (cmd.stuff_step || !cmd.bit_val) ? ~tone_ff : tone_ff;
   end

   // Advance the state for one step
   always_comb begin
      crc_in  = crc_ff;
      tone_in = tone_ff;
      ones_in = ones_ff;
      if (cmd.restart) begin
         crc_in = CRC_INIT;
      end
      if (cmd.bit_step) begin
         crc_in  = crc_step;
         tone_in = sym_tone;
         ones_in = cmd.bit_val ? ones_inc : 3'd0;
      end
      if (cmd.stuff_step) begin
         tone_in = sym_tone;
         ones_in = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CRC_INIT;
         tone_ff <= 1'b1;
         ones_ff <= 3'd0;
      end else begin
         crc_ff  <= crc_in;
         tone_ff <= tone_in;
         ones_ff <= ones_in;
      end
   end

   assign unit.crc        = crc_ff;
   assign unit.sym_tone   = sym_tone;
   assign unit.need_stuff = cmd.stuffing && cmd.bit_val && (ones_inc >= ONES_STUFF);

endmodule

>>> rtl/hdlctx_seq.sv
module hdlctx_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hdlctx_pkg::req_type  req_payload,
   input  logic                 slot_free,
   input  hdlctx_pkg::unit_type unit,
   output hdlctx_pkg::cmd_type  cmd,
   output logic                 sym_valid,
   output hdlctx_pkg::rsp_type  sym
);
   import hdlctx_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_BIT   = 3'b010,
      ST_STUFF = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [15:0] shift_ff, shift_in;
   logic [4:0]  count_ff, count_in;
   logic        stuffing_ff, stuffing_in;
   op_type      op;

   assign op        = op_type'(req_payload.operation);
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      shift_in     = shift_ff;
      count_in     = count_ff;
      stuffing_in  = stuffing_ff;
      cmd          = '0;
      cmd.bit_val  = shift_ff[0];
      cmd.stuffing = stuffing_ff;
      sym_valid    = 1'b0;
      sym          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            // Load the bits of a new item
            if (req_valid) begin
               cmd.restart = req_payload.restart_crc && (op != OP_NONE);
               unique case (op)
                  OP_STUFFED: begin
                     shift_in    = {8'h00, req_payload.data_byte};
                     count_in    = BYTE_BITS;
                     stuffing_in = 1'b1;
                     state_in    = ST_BIT;
                  end
                  OP_PLAIN: begin
                     shift_in    = {8'h00, req_payload.data_byte};
                     count_in    = BYTE_BITS;
                     stuffing_in = 1'b0;
                     state_in    = ST_BIT;
                  end
                  OP_FCS: begin
                     shift_in    = req_payload.restart_crc ? ~CRC_INIT : ~unit.crc;
                     count_in    = FCS_BITS;
                     stuffing_in = 1'b1;
                     state_in    = ST_BIT;
                  end
                  OP_NONE: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_BIT: begin
            // Send one source bit, then stuff or advance
            if (slot_free) begin
               cmd.bit_step = 1'b1;
               sym_valid    = 1'b1;
               sym.tone     = unit.sym_tone;
               sym.stuffed  = 1'b0;
               sym.last     = (count_ff == 5'd1) && !unit.need_stuff;
               shift_in     = {1'b0, shift_ff[15:1]};
               count_in     = count_ff - 5'd1;
               if (unit.need_stuff) begin
                  state_in = ST_STUFF;
               end else if (count_ff == 5'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_STUFF: begin
            // Insert the stuff toggle
            if (slot_free) begin
               cmd.stuff_step = 1'b1;
               sym_valid      = 1'b1;
               sym.tone       = unit.sym_tone;
               sym.stuffed    = 1'b1;
               sym.last       = (count_ff == 5'd0);
               state_in       = (count_ff == 5'd0) ? ST_IDLE : ST_BIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      count_ff    <= count_in;
      stuffing_ff <= stuffing_in;
   end

endmodule

>>> rtl/hdlc_nrzi_bit_stuffing_transmitter.sv
// HDLC bit-serial transmitter with NRZI tone coding, bit stuffing and a running
// CRC-16/X.25. Each accepted item is a stuffed data byte, an unstuffed byte such as
// the 0x7E flag, or an FCS request that sends the complemented CRC low byte first;
// bits go out LSB first, one line symbol per result item. A sequencer steps a single
// bit unit (CRC shift, NRZI toggle, ones-run count) once per cycle while rsp_ready
// is high: a byte is accepted, then its 8 bits go out with any stuff bits inserted
// (at most two), and an FCS request is accepted, then sends 16 bits plus its stuff
// bits (at most four). The output register is refilled in the cycle its symbol is
// taken, so within an item symbols stream with no gap; while a symbol waits, the
// sequencer holds. req_ready is high only between items. Operation code 3 is accepted
// and dropped with no symbols and no state change.
module hdlc_nrzi_bit_stuffing_transmitter (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  hdlctx_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output hdlctx_pkg::rsp_type rsp_payload
);
   import hdlctx_pkg::*;

   cmd_type  cmd;
   unit_type unit;
   logic     slot_free;
   logic     sym_valid;
   rsp_type  sym;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff, rsp_data_in;

   hdlctx_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .slot_free   (slot_free),
      .unit        (unit),
      .cmd         (cmd),
      .sym_valid   (sym_valid),
      .sym         (sym)
   );

   hdlctx_bit_unit u_bit_unit (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .unit  (unit)
   );

   // Hold a symbol until taken; refill in the cycle it leaves
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (slot_free) begin
         rsp_valid_in = sym_valid;
         rsp_data_in  = sym;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

>>> verif/hdlc_tx_line_checker.sv
module hdlc_tx_line_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  hdlctx_pkg::req_type req_payload,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  hdlctx_pkg::rsp_type rsp_payload,
   output int                  fail_count,
   output int                  pending_count,
   output int                  symbol_count,
   output int                  stuff_count
);
   import hdlctx_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Own copy of the line state
   logic [15:0] crc_acc;
   logic        line_tone;
   logic [2:0]  ones_count;

   // Line symbols still owed by the block, oldest first
   rsp_type     expected_symbols[$];
   rsp_type     oldest_symbol;

   task automatic report_fault(input string msg);
      if (fail_count < 40) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
      fail_count++;
   endtask

   function automatic void push_symbol(input logic stuff_bit);
      rsp_type sym;
      sym.tone    = line_tone;
      sym.stuffed = stuff_bit;
      sym.last    = 1'b0;
      expected_symbols.push_back(sym);
   endfunction

   // Shift one byte out LSB first: CRC, NRZI and stuffing per bit
   function automatic void encode_byte(input logic [7:0] value, input logic stuffing);
      logic bit_val;
      logic feedback;
      for (int i = 0; i < 8; i++) begin
         bit_val  = value[i];
         feedback = crc_acc[0] ^ bit_val;
         crc_acc  = crc_acc >> 1;
         if (feedback) begin
            crc_acc = crc_acc ^ CRC_POLY;
         end
         if (bit_val) begin
            // a one holds the tone
            push_symbol(1'b0);
            if (ones_count < ONES_MAX) begin
               ones_count = ones_count + 3'd1;
            end
            if (stuffing && ones_count >= ONES_STUFF) begin
               line_tone  = ~line_tone;
               push_symbol(1'b1);
               ones_count = '0;
            end
         end else begin
            // a zero toggles the tone
            line_tone  = ~line_tone;
            push_symbol(1'b0);
            ones_count = '0;
         end
      end
   endfunction

   // Work out every symbol that one item causes
   function automatic void encode_item(input req_type item);
      int          start;
      logic [15:0] fcs;
      if (item.operation == OP_NONE) begin
         return;
      end
      start = expected_symbols.size();
      if (item.restart_crc) begin
         crc_acc = CRC_INIT;
      end
      case (op_type'(item.operation))
         OP_STUFFED: begin
            encode_byte(item.data_byte, 1'b1);
         end
         OP_PLAIN: begin
            encode_byte(item.data_byte, 1'b0);
         end
         OP_FCS: begin
            fcs = ~crc_acc;
            encode_byte(fcs[7:0], 1'b1);
            encode_byte(fcs[15:8], 1'b1);
         end
         default: begin
         end
      endcase
      if (expected_symbols.size() > start) begin
         expected_symbols[expected_symbols.size() - 1].last = 1'b1;
      end
   endfunction

   // Compare taken symbols first, then add what a newly taken item owes
   always @(posedge clock) begin
      if (reset) begin
         crc_acc    = CRC_INIT;
         line_tone  = 1'b1;
         ones_count = '0;
         expected_symbols.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_symbols.size() == 0) begin
               report_fault($sformatf("symbol tone=%0b stuffed=%0b last=%0b with none expected",
                                      rsp_payload.tone, rsp_payload.stuffed,
                                      rsp_payload.last));
            end else begin
               oldest_symbol = expected_symbols.pop_front();
               symbol_count++;
               if (oldest_symbol.stuffed) begin
                  stuff_count++;
               end
               if (rsp_payload.tone !== oldest_symbol.tone) begin
                  report_fault($sformatf("symbol %0d tone: expected %0b, got %0b",
                                         symbol_count, oldest_symbol.tone, rsp_payload.tone));
               end
               if (rsp_payload.stuffed !== oldest_symbol.stuffed) begin
                  report_fault($sformatf("symbol %0d stuffed: expected %0b, got %0b",
                                         symbol_count, oldest_symbol.stuffed,
                                         rsp_payload.stuffed));
               end
               if (rsp_payload.last !== oldest_symbol.last) begin
                  report_fault($sformatf("symbol %0d last: expected %0b, got %0b",
                                         symbol_count, oldest_symbol.last, rsp_payload.last));
               end
            end
         end
         if (req_valid && req_ready) begin
            encode_item(req_payload);
         end
      end
      pending_count <= expected_symbols.size();
   end

endmodule

>>> verif/hdlc_nrzi_bit_stuffing_transmitter_tb.sv
module hdlc_nrzi_bit_stuffing_transmitter_tb;
   import hdlctx_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         RANDOM_ITEMS = 255;
   localparam int         STALL_LIMIT  = 1000;
   localparam int         TAIL_CYCLES  = 24;
   localparam logic [7:0] FLAG_BYTE    = 8'h7E;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   int      fail_count;
   int      pending_count;
   int      symbol_count;
   int      stuff_count;
   int      op_seen[4];
   int      quiet_cycles;
   int      stall_left;
   bit      calm;

   hdlc_nrzi_bit_stuffing_transmitter DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   hdlc_tx_line_checker line_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .symbol_count  (symbol_count),
      .stuff_count   (stuff_count)
   );

   // Clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         return $urandom_range(1, 3);
      end else if (pick < 95) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(11, 40);
   endfunction

   function automatic int sender_gap();
      if (calm || $urandom_range(0, 9) < 6) begin
         return 0;
      end
      return idle_length();
   endfunction

   function automatic req_type make_req(input op_type op, input logic [7:0] value,
                                        input logic restart);
      req_type item;
      item.operation   = op;
      item.data_byte   = value;
      item.restart_crc = restart;
      return item;
   endfunction

   // Favour bytes with long runs of ones so that stuffing is hit often
   function automatic logic [7:0] frame_byte();
      case ($urandom_range(0, 7))
         0, 1: return 8'hFF;
         2:    return FLAG_BYTE;
         default: return 8'($urandom);
      endcase
   endfunction

   // Offer one item, hold it until taken, then maybe idle
   task automatic send_item(input req_type item);
      int gap;
      req_payload <= item;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      op_seen[item.operation]++;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off the sender until every owed symbol has come out
   task automatic drain_symbols();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // Flags, data opened by a CRC restart, FCS, closing flag; some frames broken
   task automatic send_frame();
      int n_flags;
      int n_data;
      bit broken;
      n_flags = $urandom_range(1, 3);
      n_data  = $urandom_range(1, 12);
      broken  = ($urandom_range(0, 7) == 0);
      repeat (n_flags) send_item(make_req(OP_PLAIN, FLAG_BYTE, 1'b0));
      for (int i = 0; i < n_data; i++) begin
         send_item(make_req(OP_STUFFED, frame_byte(), i == 0));
      end
      if (!broken) begin
         send_item(make_req(OP_FCS, 8'($urandom), 1'b0));
      end else if ($urandom_range(0, 1) == 1) begin
         send_item(make_req(OP_FCS, 8'($urandom), 1'b1));
      end
      send_item(make_req(OP_PLAIN, FLAG_BYTE, 1'b0));
   endtask

   // Receiver: ready most of the time, with random stalls
   initial begin
      rsp_ready  <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) begin
               stall_left = idle_length();
            end
         end
      end
   end

   // Watchdog on cycles with no item taken on either side
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT - 1) begin
         $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
         $display("FAIL hdlc_nrzi_bit_stuffing_transmitter");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus and verdict
   initial begin
      int useful_start;
      req_valid   <= 1'b0;
      req_payload <= '0;
      reset       <= 1'b1;
      calm        = 1'b0;
      foreach (op_seen[i]) op_seen[i] = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every operation, saturated runs, runs across items
      send_item(make_req(OP_PLAIN,   FLAG_BYTE, 1'b1));
      send_item(make_req(OP_STUFFED, 8'h00,     1'b0));
      send_item(make_req(OP_STUFFED, 8'hFF,     1'b0));
      send_item(make_req(OP_STUFFED, 8'h1F,     1'b0));
      send_item(make_req(OP_FCS,     8'h00,     1'b0));
      send_item(make_req(OP_PLAIN,   8'hFF,     1'b0));
      send_item(make_req(OP_PLAIN,   8'hFF,     1'b0));
      send_item(make_req(OP_STUFFED, 8'h01,     1'b0));
      send_item(make_req(OP_NONE,    8'hFF,     1'b1));
      send_item(make_req(OP_FCS,     8'hFF,     1'b1));
      send_item(make_req(OP_PLAIN,   FLAG_BYTE, 1'b0));
      send_item(make_req(OP_STUFFED, 8'hF8,     1'b0));
      send_item(make_req(OP_STUFFED, 8'h03,     1'b0));
      send_item(make_req(OP_STUFFED, 8'hAA,     1'b0));
      send_item(make_req(OP_STUFFED, 8'h55,     1'b0));
      send_item(make_req(OP_PLAIN,   8'h00,     1'b0));
      send_item(make_req(OP_FCS,     8'hFF,     1'b0));
      send_item(make_req(OP_NONE,    8'h00,     1'b0));
      send_item(make_req(OP_PLAIN,   8'hFF,     1'b1));
      send_item(make_req(OP_FCS,     8'h00,     1'b0));
      send_item(make_req(OP_PLAIN,   FLAG_BYTE, 1'b0));
      send_item(make_req(OP_STUFFED, 8'h80,     1'b1));
      drain_symbols();

      // Random: mostly frames with random content, the rest raw items
      useful_start = op_seen[OP_STUFFED] + op_seen[OP_PLAIN] + op_seen[OP_FCS];
      while (op_seen[OP_STUFFED] + op_seen[OP_PLAIN] + op_seen[OP_FCS] - useful_start
             < RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 3) != 0) begin
            send_frame();
         end else begin
            send_item(make_req(op_type'($urandom_range(0, 3)), 8'($urandom),
                               1'($urandom_range(0, 1))));
         end
         if ($urandom_range(0, 9) == 0) begin
            drain_symbols();
         end
      end
      calm = 1'b0;
      drain_symbols();

      $display("Sent %0d stuffed, %0d plain, %0d FCS and %0d ignored items;",
               op_seen[OP_STUFFED], op_seen[OP_PLAIN], op_seen[OP_FCS], op_seen[OP_NONE]);
      $display("checked %0d line symbols, %0d of them stuff bits.", symbol_count, stuff_count);
      if (pending_count != 0) begin
         $display("%0d expected symbols never came out", pending_count);
      end
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS hdlc_nrzi_bit_stuffing_transmitter");
      end else begin
         $display("FAIL hdlc_nrzi_bit_stuffing_transmitter");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/hdlctx_pkg.sv
rtl/hdlctx_bit_unit.sv
rtl/hdlctx_seq.sv
rtl/hdlc_nrzi_bit_stuffing_transmitter.sv
verif/hdlc_tx_line_checker.sv
verif/hdlc_nrzi_bit_stuffing_transmitter_tb.sv
